// ===== rtl/tmhm_pkg.sv =====
// Shared constants, codes and types of the timeout min-heap manager
`timescale 1ns / 1ps

package tmhm_pkg;

   // default number of handle slots
   localparam int SLOTS_DEFAULT = 64;

   // field widths of the item channels
   localparam int FUNC_W     = 2;
   localparam int HANDLE_W   = 6;
   localparam int DEADLINE_W = 64;
   localparam int KIND_W     = 8;
   localparam int PAYLOAD_W  = 64;
   localparam int STATUS_W   = 2;
   localparam int SLOT_W     = 6;
   localparam int OCC_W      = 7;

   // free-slot search looks at this many live bits per cycle
   localparam int SCAN_CHUNK = 8;
   localparam int SCAN_BITS  = $clog2(SCAN_CHUNK);

   // operation codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_CANCEL = 2'd1,
      FUNC_POP    = 2'd2,
      FUNC_PEEK   = 2'd3
   } func_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 2'd0,
      STAT_FULL       = 2'd1,
      STAT_EMPTY      = 2'd2,
      STAT_BAD_HANDLE = 2'd3
   } status_type;

   // command broadcast to the heap cells
   typedef struct packed {
      logic load;      // write a node into one cell
      logic at_match;  // target is the cell holding the key slot, else the cell at load_pos
      logic tok_up;    // loaded node starts with an upward sift token
      logic tok_dn;    // loaded node starts with a downward sift token
   } heap_cmd_type;

endpackage

// ===== rtl/tmhm_cell.sv =====
// One heap node cell: holds a slot number and deadline and swaps with its tree neighbors
`timescale 1ns / 1ps

module tmhm_cell #(
   parameter int IDX = 0,
   parameter int SW  = 6,
   parameter int CW  = 7
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tmhm_pkg::heap_cmd_type           cmd,
   input  logic [CW-1:0]                    load_pos,
   input  logic [SW-1:0]                    key_slot,
   input  logic [SW-1:0]                    new_slot,
   input  logic [tmhm_pkg::DEADLINE_W-1:0]  new_dl,
   input  logic [CW-1:0]                    count,
   input  logic [SW-1:0]                    par_slot,
   input  logic [tmhm_pkg::DEADLINE_W-1:0]  par_dl,
   input  logic                             par_swap_me,
   input  logic [SW-1:0]                    l_slot,
   input  logic [tmhm_pkg::DEADLINE_W-1:0]  l_dl,
   input  logic                             l_swap_up,
   input  logic [SW-1:0]                    r_slot,
   input  logic [tmhm_pkg::DEADLINE_W-1:0]  r_dl,
   input  logic                             r_swap_up,
   output logic [SW-1:0]                    node_slot,
   output logic [tmhm_pkg::DEADLINE_W-1:0]  node_dl,
   output logic                             swap_up,
   output logic                             swap_dn_l,
   output logic                             swap_dn_r,
   output logic                             tok
);

   localparam bit HAS_PARENT = (IDX > 0);

   logic [SW-1:0]                   slot_ff, slot_in;
   logic [tmhm_pkg::DEADLINE_W-1:0] dl_ff, dl_in;
   logic                            up_ff, up_in;
   logic                            dn_ff, dn_in;

   logic                            l_ok, r_ok, lt_l, lt_r;
   logic [tmhm_pkg::DEADLINE_W-1:0] best_dl;
   logic                            up_go, dn_go, go_l, go_r, sel;

   // local compare against parent and children
   always_comb begin
      l_ok    = 32'(count) > 32'(2 * IDX + 1);
      r_ok    = 32'(count) > 32'(2 * IDX + 2);
      lt_l    = l_ok && (l_dl < dl_ff);
      best_dl = lt_l ? l_dl : dl_ff;
      lt_r    = r_ok && (r_dl < best_dl);
      up_go   = up_ff && HAS_PARENT && (par_dl > dl_ff);
      dn_go   = dn_ff && !up_go && (lt_l || lt_r);
      go_r    = dn_go && lt_r;
      go_l    = dn_go && lt_l && !lt_r;
      sel     = cmd.load && (cmd.at_match ?
                   ((slot_ff == key_slot) && (32'(count) > 32'(IDX))) :
                   (32'(load_pos) == 32'(IDX)));
   end

   // next node and sift token
   always_comb begin
      slot_in = slot_ff;
      dl_in   = dl_ff;
      if (sel) begin
         slot_in = new_slot;
         dl_in   = new_dl;
      end else if (up_go || par_swap_me) begin
         slot_in = par_slot;
         dl_in   = par_dl;
      end else if (go_l || l_swap_up) begin
         slot_in = l_slot;
         dl_in   = l_dl;
      end else if (go_r || r_swap_up) begin
         slot_in = r_slot;
         dl_in   = r_dl;
      end
      up_in = sel ? cmd.tok_up : (l_swap_up || r_swap_up);
      dn_in = sel ? cmd.tok_dn : par_swap_me;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff <= 1'b0;
         dn_ff <= 1'b0;
      end else begin
         up_ff <= up_in;
         dn_ff <= dn_in;
      end
      slot_ff <= slot_in;
      dl_ff   <= dl_in;
   end

   assign node_slot = slot_ff;
   assign node_dl   = dl_ff;
   assign swap_up   = up_go;
   assign swap_dn_l = go_l;
   assign swap_dn_r = go_r;
   assign tok       = up_ff | dn_ff;

endmodule

// ===== rtl/tmhm_chain.sv =====
// Row of heap cells wired as a binary tree, with root, last-node and busy taps
`timescale 1ns / 1ps

module tmhm_chain #(
   parameter int SLOTS = tmhm_pkg::SLOTS_DEFAULT,
   parameter int SW    = 6,
   parameter int CW    = 7
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tmhm_pkg::heap_cmd_type           cmd,
   input  logic [CW-1:0]                    load_pos,
   input  logic [SW-1:0]                    key_slot,
   input  logic [SW-1:0]                    new_slot,
   input  logic [tmhm_pkg::DEADLINE_W-1:0]  new_dl,
   input  logic [CW-1:0]                    count,
   output logic [SW-1:0]                    root_slot,
   output logic [tmhm_pkg::DEADLINE_W-1:0]  root_dl,
   output logic [SW-1:0]                    last_slot,
   output logic [tmhm_pkg::DEADLINE_W-1:0]  last_dl,
   output logic                             busy
);

   logic [SW-1:0]                   slot_a [SLOTS];
   logic [tmhm_pkg::DEADLINE_W-1:0] dl_a   [SLOTS];
   logic [SLOTS-1:0]                up_a, dnl_a, dnr_a, tok_a;

   // cell i has parent (i-1)/2 and children 2i+1, 2i+2
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic [SW-1:0]                   ps, ls, rs;
      logic [tmhm_pkg::DEADLINE_W-1:0] pd, ld, rd;
      logic                            pswap, lup, rup;

      if (i > 0) begin : g_par
         assign ps    = slot_a[(i - 1) / 2];
         assign pd    = dl_a[(i - 1) / 2];
         assign pswap = (i % 2 == 1) ? dnl_a[(i - 1) / 2] : dnr_a[(i - 1) / 2];
      end else begin : g_root
         assign ps    = '0;
         assign pd    = '0;
         assign pswap = 1'b0;
      end

      if (2 * i + 1 < SLOTS) begin : g_left
         assign ls  = slot_a[2 * i + 1];
         assign ld  = dl_a[2 * i + 1];
         assign lup = up_a[2 * i + 1];
      end else begin : g_no_left
         assign ls  = '0;
         assign ld  = '0;
         assign lup = 1'b0;
      end

      if (2 * i + 2 < SLOTS) begin : g_right
         assign rs  = slot_a[2 * i + 2];
         assign rd  = dl_a[2 * i + 2];
         assign rup = up_a[2 * i + 2];
      end else begin : g_no_right
         assign rs  = '0;
         assign rd  = '0;
         assign rup = 1'b0;
      end

      tmhm_cell #(
         .IDX (i),
         .SW  (SW),
         .CW  (CW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .load_pos    (load_pos),
         .key_slot    (key_slot),
         .new_slot    (new_slot),
         .new_dl      (new_dl),
         .count       (count),
         .par_slot    (ps),
         .par_dl      (pd),
         .par_swap_me (pswap),
         .l_slot      (ls),
         .l_dl        (ld),
         .l_swap_up   (lup),
         .r_slot      (rs),
         .r_dl        (rd),
         .r_swap_up   (rup),
         .node_slot   (slot_a[i]),
         .node_dl     (dl_a[i]),
         .swap_up     (up_a[i]),
         .swap_dn_l   (dnl_a[i]),
         .swap_dn_r   (dnr_a[i]),
         .tok         (tok_a[i])
      );
   end

   // node at position count-1, picked by and-or over the row
   always_comb begin
      last_slot = '0;
      last_dl   = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (32'(count) == 32'(i + 1)) begin
            last_slot = last_slot | slot_a[i];
            last_dl   = last_dl | dl_a[i];
         end
      end
   end

   assign root_slot = slot_a[0];
   assign root_dl   = dl_a[0];
   assign busy      = |tok_a;

endmodule

// ===== rtl/timeout_min_heap_manager_core.sv =====
// Top level of the timeout min-heap manager: sequencer, slot table and heap cell row
`timescale 1ns / 1ps

// Usage: one request item on the req_ channel (valid/ready) carries an operation
// (insert, cancel, pop, peek) with its handle, deadline, kind and payload. Each
// item gives exactly one result item on the rsp_ channel (valid/ready) with
// status, slot, the entry fields of a popped or peeked entry and the occupancy.
// Items are worked on one at a time. A rejected operation (full, empty, bad
// handle) goes from decode straight to the result; peek and pop read the slot
// table at the root slot, and pop then loads the last node at the root and sifts
// it down unless it took the only entry; cancel loads the last node into the gap
// and sifts it either way unless the entry was the last heap node; insert scans
// the 8-slot groups for the lowest free slot, then loads at the end and sifts up.
// The sift is carried out by the row of heap cells, one level per cycle; the
// free-slot search looks at 8 live bits per cycle. A result waits in an output
// register, so the next item is accepted while it is unread; if the receiver
// stalls, the following item finishes its work and then holds until the register
// is free.
// Synchronous reset empties the heap and frees every slot.

module timeout_min_heap_manager_core #(
   parameter int SLOTS = tmhm_pkg::SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [tmhm_pkg::FUNC_W-1:0]      req_func,
   input  logic [tmhm_pkg::HANDLE_W-1:0]    req_handle,
   input  logic [tmhm_pkg::DEADLINE_W-1:0]  req_deadline,
   input  logic [tmhm_pkg::KIND_W-1:0]      req_kind,
   input  logic [tmhm_pkg::PAYLOAD_W-1:0]   req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tmhm_pkg::STATUS_W-1:0]    rsp_status,
   output logic [tmhm_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [tmhm_pkg::DEADLINE_W-1:0]  rsp_due_time,
   output logic [tmhm_pkg::KIND_W-1:0]      rsp_entry_kind,
   output logic [tmhm_pkg::PAYLOAD_W-1:0]   rsp_entry_payload,
   output logic [tmhm_pkg::OCC_W-1:0]       rsp_occupancy
);

   localparam int SW     = $clog2(SLOTS);
   localparam int CW     = $clog2(SLOTS + 1);
   localparam int CHUNKS = (SLOTS + tmhm_pkg::SCAN_CHUNK - 1) / tmhm_pkg::SCAN_CHUNK;
   localparam int PADW   = CHUNKS * tmhm_pkg::SCAN_CHUNK;
   localparam int CKW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECODE = 7'b0000010,
      ST_SCAN   = 7'b0000100,
      ST_LOAD   = 7'b0001000,
      ST_READ   = 7'b0010000,
      ST_SIFT   = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type                        state_ff, state_in;
   tmhm_pkg::func_type               func_ff, func_in;
   logic [tmhm_pkg::HANDLE_W-1:0]    handle_ff, handle_in;
   logic [tmhm_pkg::DEADLINE_W-1:0]  dl_ff, dl_in;
   logic [tmhm_pkg::KIND_W-1:0]      kind_ff, kind_in;
   logic [tmhm_pkg::PAYLOAD_W-1:0]   pay_ff, pay_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [SLOTS-1:0]                 live_ff, live_in;
   logic [CKW-1:0]                   scan_ff, scan_in;
   logic [SW-1:0]                    last_slot_ff, last_slot_in;
   logic [tmhm_pkg::DEADLINE_W-1:0]  last_dl_ff, last_dl_in;

   tmhm_pkg::status_type             res_status_ff, res_status_in;
   logic [SW-1:0]                    res_slot_ff, res_slot_in;
   logic [tmhm_pkg::DEADLINE_W-1:0]  res_due_ff, res_due_in;
   logic [tmhm_pkg::KIND_W-1:0]      res_kind_ff, res_kind_in;
   logic [tmhm_pkg::PAYLOAD_W-1:0]   res_pay_ff, res_pay_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   tmhm_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [tmhm_pkg::SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic [tmhm_pkg::DEADLINE_W-1:0]  rsp_due_ff, rsp_due_in;
   logic [tmhm_pkg::KIND_W-1:0]      rsp_kind_ff, rsp_kind_in;
   logic [tmhm_pkg::PAYLOAD_W-1:0]   rsp_pay_ff, rsp_pay_in;
   logic [tmhm_pkg::OCC_W-1:0]       rsp_occ_ff, rsp_occ_in;

   // slot table memories and their registered read data
   logic [tmhm_pkg::KIND_W-1:0]      kind_mem [SLOTS];
   logic [tmhm_pkg::PAYLOAD_W-1:0]   pay_mem  [SLOTS];
   logic [tmhm_pkg::KIND_W-1:0]      rd_kind_ff;
   logic [tmhm_pkg::PAYLOAD_W-1:0]   rd_pay_ff;
   logic                             mem_we;

   // heap row interface
   tmhm_pkg::heap_cmd_type           cmd;
   logic [CW-1:0]                    load_pos;
   logic [SW-1:0]                    new_slot;
   logic [tmhm_pkg::DEADLINE_W-1:0]  new_dl;
   logic [SW-1:0]                    key_slot;
   logic [SW-1:0]                    root_slot, last_slot;
   logic [tmhm_pkg::DEADLINE_W-1:0]  root_dl, last_dl;
   logic                             busy;

   // free-slot search
   logic [PADW-1:0]                  live_pad;
   logic [tmhm_pkg::SCAN_CHUNK-1:0]  chunk;
   logic                             found;
   logic [tmhm_pkg::SCAN_BITS-1:0]   first_free;
   logic [SW-1:0]                    free_slot;
   logic                             handle_ok;

   assign key_slot  = SW'(handle_ff);
   assign handle_ok = 32'(handle_ff) < 32'(SLOTS);

   // lowest clear live bit of the current group, padding reads as taken
   always_comb begin
      live_pad = '1;
      live_pad[SLOTS-1:0] = live_ff;
      chunk = live_pad[scan_ff * tmhm_pkg::SCAN_CHUNK +: tmhm_pkg::SCAN_CHUNK];
      found = 1'b0;
      first_free = '0;
      for (int b = tmhm_pkg::SCAN_CHUNK - 1; b >= 0; b--) begin
         if (!chunk[b]) begin
            found = 1'b1;
            first_free = tmhm_pkg::SCAN_BITS'(b);
         end
      end
      free_slot = SW'({scan_ff, first_free});
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      handle_in     = handle_ff;
      dl_in         = dl_ff;
      kind_in       = kind_ff;
      pay_in        = pay_ff;
      count_in      = count_ff;
      live_in       = live_ff;
      scan_in       = scan_ff;
      last_slot_in  = last_slot_ff;
      last_dl_in    = last_dl_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_due_in    = res_due_ff;
      res_kind_in   = res_kind_ff;
      res_pay_in    = res_pay_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_due_in    = rsp_due_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_occ_in    = rsp_occ_ff;
      cmd           = '0;
      load_pos      = count_ff;
      new_slot      = last_slot_ff;
      new_dl        = last_dl_ff;
      mem_we        = 1'b0;

      // result taken by the receiver
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in   = tmhm_pkg::func_type'(req_func);
               handle_in = req_handle;
               dl_in     = req_deadline;
               kind_in   = req_kind;
               pay_in    = req_payload;
               state_in  = ST_DECODE;
            end
         end

         ST_DECODE: begin
            res_status_in = tmhm_pkg::STAT_OK;
            res_slot_in   = '0;
            res_due_in    = '0;
            res_kind_in   = '0;
            res_pay_in    = '0;
            case (func_ff)
               tmhm_pkg::FUNC_INSERT: begin
                  if (count_ff == CW'(SLOTS)) begin
                     res_status_in = tmhm_pkg::STAT_FULL;
                     state_in      = ST_DONE;
                  end else begin
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end
               end
               tmhm_pkg::FUNC_CANCEL: begin
                  if (!(handle_ok && live_ff[key_slot])) begin
                     res_status_in = tmhm_pkg::STAT_BAD_HANDLE;
                     state_in      = ST_DONE;
                  end else begin
                     live_in[key_slot] = 1'b0;
                     last_slot_in      = last_slot;
                     last_dl_in        = last_dl;
                     count_in          = count_ff - 1'b1;
                     state_in          = ST_LOAD;
                  end
               end
               default: begin
                  // pop and peek
                  if (count_ff == '0) begin
                     res_status_in = tmhm_pkg::STAT_EMPTY;
                     state_in      = ST_DONE;
                  end else begin
                     res_slot_in = root_slot;
                     res_due_in  = root_dl;
                     if (func_ff == tmhm_pkg::FUNC_POP) begin
                        live_in[root_slot] = 1'b0;
                        last_slot_in       = last_slot;
                        last_dl_in         = last_dl;
                        count_in           = count_ff - 1'b1;
                     end
                     state_in = ST_READ;
                  end
               end
            endcase
         end

         ST_SCAN: begin
            if (found) begin
               mem_we             = 1'b1;
               live_in[free_slot] = 1'b1;
               cmd.load           = 1'b1;
               cmd.tok_up         = 1'b1;
               load_pos           = count_ff;
               new_slot           = free_slot;
               new_dl             = dl_ff;
               count_in           = count_ff + 1'b1;
               res_slot_in        = free_slot;
               state_in           = ST_SIFT;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         ST_LOAD: begin
            // last node fills the gap of the cancelled slot, sifts either way
            cmd.load     = 1'b1;
            cmd.at_match = 1'b1;
            cmd.tok_up   = 1'b1;
            cmd.tok_dn   = 1'b1;
            state_in     = ST_SIFT;
         end

         ST_READ: begin
            res_kind_in = rd_kind_ff;
            res_pay_in  = rd_pay_ff;
            if (func_ff == tmhm_pkg::FUNC_POP && count_ff != '0) begin
               cmd.load   = 1'b1;
               cmd.tok_dn = 1'b1;
               load_pos   = '0;
               state_in   = ST_SIFT;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_SIFT: begin
            if (!busy) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = tmhm_pkg::SLOT_W'(res_slot_ff);
               rsp_due_in    = res_due_ff;
               rsp_kind_in   = res_kind_ff;
               rsp_pay_in    = res_pay_ff;
               rsp_occ_in    = tmhm_pkg::OCC_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      handle_ff     <= handle_in;
      dl_ff         <= dl_in;
      kind_ff       <= kind_in;
      pay_ff        <= pay_in;
      scan_ff       <= scan_in;
      last_slot_ff  <= last_slot_in;
      last_dl_ff    <= last_dl_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_due_ff    <= res_due_in;
      res_kind_ff   <= res_kind_in;
      res_pay_ff    <= res_pay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_due_ff    <= rsp_due_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // slot table: written on insert, read at the root slot
   always_ff @(posedge clock) begin
      if (mem_we) begin
         kind_mem[free_slot] <= kind_ff;
         pay_mem[free_slot]  <= pay_ff;
      end
      rd_kind_ff <= kind_mem[root_slot];
      rd_pay_ff  <= pay_mem[root_slot];
   end

   tmhm_chain #(
      .SLOTS (SLOTS),
      .SW    (SW),
      .CW    (CW)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .load_pos  (load_pos),
      .key_slot  (key_slot),
      .new_slot  (new_slot),
      .new_dl    (new_dl),
      .count     (count_ff),
      .root_slot (root_slot),
      .root_dl   (root_dl),
      .last_slot (last_slot),
      .last_dl   (last_dl),
      .busy      (busy)
   );

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_due_time      = rsp_due_ff;
   assign rsp_entry_kind    = rsp_kind_ff;
   assign rsp_entry_payload = rsp_pay_ff;
   assign rsp_occupancy     = rsp_occ_ff;

endmodule
